[sv/dqtu_pkg.sv]
package dqtu_pkg;

  localparam int GRID_WIDTH  = 16;
  localparam int GRID_HEIGHT = 16;
  localparam int TABLE_DEPTH = GRID_WIDTH * GRID_HEIGHT * 4;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);

  typedef logic [IDX_W-1:0] idx_t;

  localparam idx_t IDX_LAST = idx_t'(TABLE_DEPTH - 1);

  // operation kinds
  localparam logic [1:0] KIND_CHOOSE = 2'd0;
  localparam logic [1:0] KIND_REAL   = 2'd1;
  localparam logic [1:0] KIND_REPLAY = 2'd2;

  // register indexes
  localparam logic [2:0] CFG_LEARN_RATE   = 3'd0;
  localparam logic [2:0] CFG_DISCOUNT     = 3'd1;
  localparam logic [2:0] CFG_BONUS_WEIGHT = 3'd2;
  localparam logic [2:0] CFG_EXPLORE_THR  = 3'd3;
  localparam logic [2:0] CFG_ROW_WIDTH    = 3'd4;
  localparam logic [2:0] CFG_BONUS_ENABLE = 3'd5;

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         pos_x;
    logic [3:0]         pos_y;
    logic [1:0]         move;
    logic signed [31:0] reward_in;
    logic [3:0]         dest_x;
    logic [3:0]         dest_y;
    logic [16:0]        draw;
    logic [1:0]         random_move;
  } in_t;

  typedef struct packed {
    logic [1:0]         chosen_move;
    logic signed [31:0] q_after;
    logic               updated;
  } out_t;

  typedef struct packed {
    logic [7:0]         dest;
    logic signed [31:0] reward;
    logic               seen;
    logic [31:0]        stamp;
  } model_t;

  typedef struct packed {
    idx_t               q_raddr;
    logic               q_we;
    idx_t               q_waddr;
    logic signed [31:0] q_wdata;
    idx_t               m_raddr;
    logic               m_we;
    idx_t               m_waddr;
    model_t             m_wdata;
  } mem_req_t;

  function automatic idx_t cell_index(logic [3:0] x, logic [3:0] y, logic [4:0] rw,
                                      logic [1:0] a);
    logic [9:0]  lin_pos;
    logic [11:0] raw;
    lin_pos = {6'b0, y} * {5'b0, rw} + {6'b0, x};
    raw     = {lin_pos, a};
    return idx_t'(raw % TABLE_DEPTH);
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [39:0] v);
    if (v > 40'sh007FFFFFFF) begin
      return 32'sh7FFFFFFF;
    end else if (v < -40'sh0080000000) begin
      return -32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

[sv/dyna_q_table_update.sv]
// Dyna-Q / Dyna-Q+ table engine. After reset the block holds busy high for a
// sweep that zeroes the Q table and the model's seen flags and stamps;
// configuration writes are taken during that sweep. An item is taken when
// start is high and busy low, and every item gives exactly one result,
// shown for a single cycle with result_valid; the receiver cannot stall, so
// capture it then. One item is in flight at a time. Kind 3 and an exploring
// kind 0 answer in the cycle after the transfer and busy stays low; a greedy
// kind 0 runs ST_GREEDY; kinds 1 and 2 run ST_MREAD (an unseen replayed
// entry ends there), then with the bonus on ST_SQRT, ST_BONUS and ST_RSUM,
// then ST_GREEDY, ST_MULG, ST_TD, ST_MULA and ST_WRITE. The iterative
// square root gives one root bit per cycle. In ST_GREEDY the single Q read
// port reads the four actions of the next cell and the updated entry one
// after another; ST_BONUS, ST_MULG and ST_MULA each register a multiply.
module dyna_q_table_update
  import dqtu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  in_t         item,
  output logic        result_valid,
  output out_t        result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_MREAD  = 10'b0000000010,
    ST_SQRT   = 10'b0000000100,
    ST_BONUS  = 10'b0000001000,
    ST_RSUM   = 10'b0000010000,
    ST_GREEDY = 10'b0000100000,
    ST_MULG   = 10'b0001000000,
    ST_TD     = 10'b0010000000,
    ST_MULA   = 10'b0100000000,
    ST_WRITE  = 10'b1000000000
  } state_t;

  // configuration registers
  logic [15:0] learn_rate;
  logic [15:0] discount;
  logic [15:0] bonus_weight;
  logic [16:0] explore_threshold;
  logic [4:0]  row_width;
  logic        bonus_enable;

  state_t      state;
  state_t      state_next;
  logic [2:0]  rd_cnt;
  logic [31:0] step_count;

  // per-item working registers
  in_t                it_r;
  idx_t               idx_r;
  logic [3:0]         nx_r;
  logic [3:0]         ny_r;
  logic signed [31:0] base_r;
  logic [31:0]        bonus_r;
  logic signed [31:0] reward_r;
  logic [1:0]         best_r;
  logic signed [31:0] bv_r;
  logic signed [31:0] q_cur;
  logic signed [32:0] gq_r;
  logic signed [34:0] td_r;
  logic signed [35:0] upd_r;

  // memory and square-root hookup
  mem_req_t           req;
  logic signed [31:0] q_rdata;
  model_t             m_rdata;
  logic               mem_ready;
  logic               sq_start;
  logic               sq_done;
  logic [31:0]        sq_root;

  logic               accept;
  logic               explore;
  idx_t               idx_in;
  logic               res_fire;
  out_t               res_next;
  logic [1:0]         rd_act;

  // arithmetic
  logic [47:0]        bprod;
  logic signed [39:0] rsum_w;
  logic signed [48:0] gprod;
  logic signed [34:0] td_w;
  logic signed [51:0] aprod;
  logic signed [31:0] nq_w;

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE) || !mem_ready;
  assign accept    = start && !busy;
  assign explore   = item.draw < explore_threshold;
  assign idx_in    = cell_index(item.pos_x, item.pos_y, row_width, item.move);
  assign rd_act    = rd_cnt[1:0] - 2'd1;

  assign bprod  = bonus_weight * sq_root;
  assign rsum_w = {{8{base_r[31]}}, base_r} + {8'b0, bonus_r};
  assign gprod  = $signed({1'b0, discount}) * bv_r;
  assign td_w   = 35'(reward_r) + 35'(gq_r) - 35'(q_cur);
  assign aprod  = $signed({1'b0, learn_rate}) * td_r;
  assign nq_w   = sat32(40'(q_cur) + 40'(upd_r));

  dqtu_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .q_rdata (q_rdata),
    .m_rdata (m_rdata),
    .ready   (mem_ready)
  );

  dqtu_isqrt u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (sq_start),
    .operand (step_count - m_rdata.stamp),
    .done    (sq_done),
    .root    (sq_root)
  );

  // next state, memory requests and result
  always_comb begin
    state_next   = state;
    res_fire     = 1'b0;
    res_next     = '0;
    sq_start     = 1'b0;
    req          = '0;
    // model read goes out in the transfer cycle so data is there in ST_MREAD
    req.m_raddr  = (state == ST_IDLE) ? idx_in : idx_r;
    req.q_raddr  = idx_r;
    if (state == ST_GREEDY && rd_cnt < 3'd4) begin
      req.q_raddr = cell_index(nx_r, ny_r, row_width, rd_cnt[1:0]);
    end
    req.q_waddr         = idx_r;
    req.q_wdata         = nq_w;
    req.m_waddr         = idx_r;
    req.m_wdata.dest    = {it_r.dest_y, it_r.dest_x};
    req.m_wdata.reward  = it_r.reward_in;
    req.m_wdata.seen    = 1'b1;
    req.m_wdata.stamp   = step_count;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (item.kind)
            KIND_CHOOSE: begin
              if (explore) begin
                res_fire             = 1'b1;
                res_next.chosen_move = item.random_move;
              end else begin
                state_next = ST_GREEDY;
              end
            end
            KIND_REAL, KIND_REPLAY: state_next = ST_MREAD;
            default: res_fire = 1'b1;
          endcase
        end
      end
      ST_MREAD: begin
        if (it_r.kind == KIND_REPLAY && !m_rdata.seen) begin
          res_fire   = 1'b1;
          state_next = ST_IDLE;
        end else if (bonus_enable) begin
          sq_start   = 1'b1;
          state_next = ST_SQRT;
        end else begin
          state_next = ST_GREEDY;
        end
      end
      ST_SQRT: begin
        if (sq_done) begin
          state_next = ST_BONUS;
        end
      end
      ST_BONUS: state_next = ST_RSUM;
      ST_RSUM:  state_next = ST_GREEDY;
      ST_GREEDY: begin
        if (rd_cnt == 3'd5) begin
          if (it_r.kind == KIND_CHOOSE) begin
            res_fire             = 1'b1;
            res_next.chosen_move = best_r;
            state_next           = ST_IDLE;
          end else begin
            state_next = ST_MULG;
          end
        end
      end
      ST_MULG: state_next = ST_TD;
      ST_TD:   state_next = ST_MULA;
      ST_MULA: state_next = ST_WRITE;
      ST_WRITE: begin
        req.q_we             = 1'b1;
        req.m_we             = (it_r.kind == KIND_REAL);
        res_fire             = 1'b1;
        res_next.chosen_move = best_r;
        res_next.q_after     = nq_w;
        res_next.updated     = 1'b1;
        state_next           = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      rd_cnt            <= '0;
      step_count        <= '0;
      result_valid      <= 1'b0;
      learn_rate        <= 16'd6554;
      discount          <= 16'd58982;
      bonus_weight      <= 16'd6554;
      explore_threshold <= 17'd10000;
      row_width         <= 5'd9;
      bonus_enable      <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= res_fire;
      // greedy read sequencer: four actions of the next cell, then the entry
      if (state == ST_GREEDY) begin
        rd_cnt <= rd_cnt + 3'd1;
      end else begin
        rd_cnt <= '0;
      end
      if (accept && item.kind == KIND_REAL) begin
        step_count <= step_count + 32'd1;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LEARN_RATE:   learn_rate        <= cfg_data[15:0];
          CFG_DISCOUNT:     discount          <= cfg_data[15:0];
          CFG_BONUS_WEIGHT: bonus_weight      <= cfg_data[15:0];
          CFG_EXPLORE_THR:  explore_threshold <= cfg_data;
          CFG_ROW_WIDTH:    row_width         <= cfg_data[4:0];
          CFG_BONUS_ENABLE: bonus_enable      <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (res_fire) begin
      result <= res_next;
    end
    if (accept) begin
      it_r   <= item;
      idx_r  <= idx_in;
      base_r <= item.reward_in;
      // kind 0 looks at its own cell, kind 1 at the destination
      if (item.kind == KIND_CHOOSE) begin
        nx_r <= item.pos_x;
        ny_r <= item.pos_y;
      end else begin
        nx_r <= item.dest_x;
        ny_r <= item.dest_y;
      end
    end
    if (state == ST_MREAD) begin
      if (it_r.kind == KIND_REPLAY) begin
        base_r   <= m_rdata.reward;
        reward_r <= m_rdata.reward;
        nx_r     <= m_rdata.dest[3:0];
        ny_r     <= m_rdata.dest[7:4];
      end else begin
        reward_r <= it_r.reward_in;
      end
    end
    if (state == ST_BONUS) begin
      bonus_r <= bprod[47:16];
    end
    if (state == ST_RSUM) begin
      reward_r <= sat32(rsum_w);
    end
    // q_rdata holds the read issued in the previous cycle
    if (state == ST_GREEDY) begin
      if (rd_cnt == 3'd1) begin
        best_r <= 2'd0;
        bv_r   <= q_rdata;
      end else if (rd_cnt >= 3'd2 && rd_cnt <= 3'd4 && q_rdata > bv_r) begin
        best_r <= rd_act;
        bv_r   <= q_rdata;
      end
      if (rd_cnt == 3'd5) begin
        q_cur <= q_rdata;
      end
    end
    if (state == ST_MULG) begin
      gq_r <= gprod[48:16];
    end
    if (state == ST_TD) begin
      td_r <= td_w;
    end
    if (state == ST_MULA) begin
      upd_r <= aprod[51:16];
    end
  end

endmodule

[sv/dqtu_isqrt.sv]
module dqtu_isqrt
  import dqtu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] operand,
  output logic        done,
  output logic [31:0] root
);

  // floor(sqrt(operand * 2^32)), one result bit per cycle
  logic        active;
  logic [4:0]  cnt;
  logic [63:0] rad;
  logic [33:0] rem;
  logic [35:0] rem_t;
  logic [35:0] trial;
  logic        ge;

  assign rem_t = {rem, rad[63:62]};
  assign trial = {2'b0, root, 2'b01};
  assign ge    = rem_t >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= active && (cnt == 5'd31);
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= {operand, 32'b0};
      rem  <= '0;
      root <= '0;
    end else if (active) begin
      rad  <= {rad[61:0], 2'b00};
      rem  <= ge ? 34'(rem_t - trial) : rem_t[33:0];
      root <= {root[30:0], ge};
    end
  end

endmodule

[sv/dqtu_mem.sv]
module dqtu_mem
  import dqtu_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  mem_req_t           req,
  output logic signed [31:0] q_rdata,
  output model_t             m_rdata,
  output logic               ready
);

  logic signed [31:0] q_mem [TABLE_DEPTH];
  model_t             m_mem [TABLE_DEPTH];

  logic clearing;
  idx_t clr_idx;

  // sweep after reset zeroes q, seen and stamp
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + idx_t'(1);
      if (clr_idx == IDX_LAST) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      q_mem[clr_idx] <= '0;
      m_mem[clr_idx] <= '0;
    end else begin
      if (req.q_we) begin
        q_mem[req.q_waddr] <= req.q_wdata;
      end
      if (req.m_we) begin
        m_mem[req.m_waddr] <= req.m_wdata;
      end
    end
    q_rdata <= q_mem[req.q_raddr];
    m_rdata <= m_mem[req.m_raddr];
  end

  assign ready = !clearing;

endmodule

[sv/dqtu_checker.sv]
module dqtu_checker
  import dqtu_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input in_t  item,
  input logic result_valid,
  input out_t result
);

  // the clearing sweep keeps the block busy right after reset
  a_busy_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> busy)
    else $error("block not busy after reset");

  a_no_update_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.updated |-> result.q_after == 32'sd0)
    else $error("q_after nonzero without an update");

  a_update_took_work: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.updated |-> $past(busy))
    else $error("update result without work cycles");

  a_choose_no_update: assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.kind == KIND_CHOOSE |=> !result.updated || !result_valid)
    else $error("choose transfer wrote the table");

  a_choose_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.kind == KIND_CHOOSE |=> result_valid || busy)
    else $error("choose transfer dropped");

endmodule

bind dyna_q_table_update dqtu_checker u_dqtu_checker (.*);

[tb/dyna_q_table_update_tb.sv]
`timescale 1ns / 1ps

module dyna_q_table_update_tb;
  import dqtu_pkg::*;

  // kind code the block must answer with an empty result
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  in_t         item;
  logic        result_valid;
  out_t        result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [16:0] cfg_data;

  dyna_q_table_update dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .result_valid(result_valid), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // shadow copy of the learner: Q table, experience model, step counter
  logic signed [31:0] q_shadow [TABLE_DEPTH];
  logic [7:0]         visit_dest [TABLE_DEPTH];
  logic signed [31:0] visit_reward [TABLE_DEPTH];
  logic               visit_seen [TABLE_DEPTH];
  int unsigned        visit_stamp [TABLE_DEPTH];
  int unsigned        real_steps;

  // shadow register file
  int unsigned alpha_q, gamma_q, kappa_q, eps_thr, cells_per_row;
  bit          bonus_on;

  out_t pending_results [$];
  int   fail_count = 0;

  // (x, y, move) triples seen in real transitions, used to steer replays
  logic [9:0] visited [$];

  function automatic int unsigned table_slot(logic [3:0] x, logic [3:0] y, logic [1:0] a);
    int unsigned raw;
    raw = (int'(y) * (cells_per_row & 5'h1f) + int'(x)) * 4 + int'(a);
    return raw % TABLE_DEPTH;
  endfunction

  // best action at a cell; ties keep the lower action
  function automatic logic [1:0] greedy_pick(logic [3:0] x, logic [3:0] y,
                                             output logic signed [31:0] best_val);
    logic [1:0] best;
    logic signed [31:0] v;
    best = 2'd0;
    best_val = q_shadow[table_slot(x, y, 2'd0)];
    for (int a = 1; a < 4; a++) begin
      v = q_shadow[table_slot(x, y, 2'(a))];
      if (v > best_val) begin
        best_val = v;
        best = 2'(a);
      end
    end
    return best;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // dyna-q+ bonus: kappa * sqrt(steps since last real visit)
  function automatic longint reward_with_bonus(longint base, int unsigned slot);
    int unsigned     elapsed;
    longint unsigned root;
    if (!bonus_on) return base;
    elapsed = real_steps - visit_stamp[slot];
    root = int_sqrt({elapsed, 32'b0});
    return clamp32(base + longint'((longint'(kappa_q) * root) >> 16));
  endfunction

  function automatic logic signed [31:0] td_update(int unsigned slot, longint rwd,
                                                   logic signed [31:0] q_next);
    longint q, gq, td, nq;
    q  = longint'(q_shadow[slot]);
    gq = (longint'(gamma_q) * longint'(q_next)) >>> 16;
    td = rwd + gq - q;
    nq = clamp32(q + ((longint'(alpha_q) * td) >>> 16));
    q_shadow[slot] = 32'(nq);
    return 32'(nq);
  endfunction

  function automatic out_t learner_step(in_t it);
    out_t               o;
    int unsigned        slot;
    logic signed [31:0] qn;
    longint             rwd;
    o = '0;
    slot = table_slot(it.pos_x, it.pos_y, it.move);
    case (it.kind)
      KIND_CHOOSE: begin
        if (int'(it.draw) < int'(eps_thr)) o.chosen_move = it.random_move;
        else o.chosen_move = greedy_pick(it.pos_x, it.pos_y, qn);
      end
      KIND_REAL: begin
        real_steps += 1;
        rwd = reward_with_bonus(longint'(it.reward_in), slot);
        o.chosen_move = greedy_pick(it.dest_x, it.dest_y, qn);
        o.q_after = td_update(slot, rwd, qn);
        o.updated = 1'b1;
        visit_dest[slot] = {it.dest_y, it.dest_x};
        visit_reward[slot] = it.reward_in;
        visit_seen[slot] = 1'b1;
        visit_stamp[slot] = real_steps;
      end
      KIND_REPLAY: begin
        if (visit_seen[slot]) begin
          rwd = reward_with_bonus(longint'(visit_reward[slot]), slot);
          o.chosen_move = greedy_pick(visit_dest[slot][3:0], visit_dest[slot][7:4], qn);
          o.q_after = td_update(slot, rwd, qn);
          o.updated = 1'b1;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // result checker: every strobed result must match the oldest prediction
  always @(posedge clk) begin
    out_t exp_r;
    if (!rst && result_valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result %p", result);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (result.chosen_move !== exp_r.chosen_move) begin
          $error("chosen_move expected %0d actual %0d", exp_r.chosen_move, result.chosen_move);
          fail_count++;
        end
        if (result.q_after !== exp_r.q_after) begin
          $error("q_after expected %0d actual %0d", exp_r.q_after, result.q_after);
          fail_count++;
        end
        if (result.updated !== exp_r.updated) begin
          $error("updated expected %0d actual %0d", exp_r.updated, result.updated);
          fail_count++;
        end
      end
    end
  end

  // one item transfer; start is left high so back-to-back items need no toggle
  task automatic send_item(in_t it, int gap_pct);
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    pending_results = {pending_results, learner_step(it)};
    if (it.kind == KIND_REAL) begin
      visited = {visited, {it.pos_x, it.pos_y, it.move}};
      if (visited.size() > 48) void'(visited.pop_front());
    end
  endtask

  // block is idle once every predicted result has come back
  task automatic drain;
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 17'(val);
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_LEARN_RATE:   alpha_q = val & 16'hffff;
      CFG_DISCOUNT:     gamma_q = val & 16'hffff;
      CFG_BONUS_WEIGHT: kappa_q = val & 16'hffff;
      CFG_EXPLORE_THR:  eps_thr = val & 17'h1ffff;
      CFG_ROW_WIDTH:    cells_per_row = val & 5'h1f;
      CFG_BONUS_ENABLE: bonus_on = val[0];
      default: ;
    endcase
  endtask

  task automatic set_regs(int unsigned lr, int unsigned dc, int unsigned bw,
                          int unsigned thr, int unsigned rw, int unsigned be);
    drain();
    write_reg(CFG_LEARN_RATE, lr);
    write_reg(CFG_DISCOUNT, dc);
    write_reg(CFG_BONUS_WEIGHT, bw);
    write_reg(CFG_EXPLORE_THR, thr);
    write_reg(CFG_ROW_WIDTH, rw);
    write_reg(CFG_BONUS_ENABLE, be);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_t make_item(logic [1:0] k, int x, int y, int mv, int rwd,
                                    int dx, int dy, int drw, int rmv);
    in_t it;
    it.kind = k;
    it.pos_x = 4'(x);
    it.pos_y = 4'(y);
    it.move = 2'(mv);
    it.reward_in = rwd;
    it.dest_x = 4'(dx);
    it.dest_y = 4'(dy);
    it.draw = 17'(drw);
    it.random_move = 2'(rmv);
    return it;
  endfunction

  function automatic logic signed [31:0] pick_reward();
    case ($urandom_range(9))
      0:       return 32'sh7fffffff;
      1:       return -32'sh80000000;
      2:       return 0;
      3, 4:    return $urandom;
      default: return $signed(19'($urandom));   // within about +-4.0
    endcase
  endfunction

  function automatic in_t random_item();
    in_t        it;
    logic [9:0] trip;
    int         sel;
    it = '0;
    it.pos_x = 4'($urandom_range(3));
    it.pos_y = 4'($urandom_range(3));
    it.move = 2'($urandom);
    it.dest_x = 4'($urandom_range(3));
    it.dest_y = 4'($urandom_range(3));
    if ($urandom_range(3) == 0) begin
      // wide positions occasionally, to exercise aliasing through the index
      it.pos_x = 4'($urandom);
      it.pos_y = 4'($urandom);
      it.dest_x = 4'($urandom);
      it.dest_y = 4'($urandom);
    end
    it.reward_in = pick_reward();
    it.draw = 17'($urandom_range(99999));
    it.random_move = 2'($urandom);
    sel = $urandom_range(99);
    if (sel < 28) begin
      it.kind = KIND_CHOOSE;
    end else if (sel < 60) begin
      it.kind = KIND_REAL;
    end else if (sel < 96) begin
      it.kind = KIND_REPLAY;
      if (visited.size() != 0 && $urandom_range(9) < 8) begin
        trip = visited[$urandom_range(visited.size() - 1)];
        {it.pos_x, it.pos_y, it.move} = trip;
      end
    end else begin
      it.kind = KIND_UNUSED;
    end
    return it;
  endfunction

  // zero table, ties, explore edges, saturation, unseen replay, unused kind
  task automatic test_directed;
    send_item(make_item(KIND_CHOOSE, 0, 0, 0, 0, 0, 0, 99999, 3), 0);
    send_item(make_item(KIND_CHOOSE, 15, 15, 0, 0, 0, 0, 0, 3), 0);
    send_item(make_item(KIND_CHOOSE, 5, 5, 0, 0, 0, 0, 9999, 2), 0);
    send_item(make_item(KIND_CHOOSE, 5, 5, 0, 0, 0, 0, 10000, 2), 0);
    send_item(make_item(KIND_REPLAY, 2, 3, 1, 0, 0, 0, 0, 0), 0);
    send_item(make_item(KIND_REAL, 1, 1, 2, 32'sh7fffffff, 15, 15, 0, 0), 0);
    send_item(make_item(KIND_REAL, 1, 1, 3, -32'sh80000000, 0, 0, 0, 0), 0);
    send_item(make_item(KIND_CHOOSE, 1, 1, 0, 0, 0, 0, 99999, 0), 0);
    send_item(make_item(KIND_REPLAY, 1, 1, 2, 0, 0, 0, 0, 0), 0);
    send_item(make_item(KIND_REAL, 15, 15, 3, 32'h00010000, 1, 1, 0, 0), 0);
    send_item(make_item(KIND_UNUSED, 15, 15, 3, -1, 15, 15, 131071, 3), 0);
    send_item(make_item(KIND_REAL, 12, 0, 1, 12345, 9, 9, 0, 0), 0);
    // max learn rate, discount and bonus: drives the value into saturation
    set_regs(65535, 65535, 65535, 100000, 16, 1);
    send_item(make_item(KIND_CHOOSE, 3, 3, 0, 0, 0, 0, 99999, 1), 0);
    send_item(make_item(KIND_REAL, 2, 2, 0, 32'sh7fffffff, 2, 2, 0, 0), 0);
    send_item(make_item(KIND_REAL, 2, 2, 0, 32'sh7fffffff, 2, 2, 0, 0), 0);
    send_item(make_item(KIND_REPLAY, 2, 2, 0, 0, 0, 0, 0, 0), 0);
    send_item(make_item(KIND_REAL, 3, 2, 1, -32'sh80000000, 3, 2, 0, 0), 0);
    send_item(make_item(KIND_REAL, 3, 2, 1, -32'sh80000000, 3, 2, 0, 0), 0);
    send_item(make_item(KIND_REPLAY, 3, 2, 1, 0, 0, 0, 0, 0), 0);
    set_regs(0, 0, 0, 0, 1, 0);
    send_item(make_item(KIND_CHOOSE, 2, 2, 0, 0, 0, 0, 0, 3), 0);
    send_item(make_item(KIND_REAL, 15, 15, 2, 32'h00050000, 0, 0, 0, 0), 0);
    send_item(make_item(KIND_REPLAY, 15, 15, 2, 0, 0, 0, 0, 0), 0);
  endtask

  task automatic test_random(int count, int gap_pct);
    for (int i = 0; i < count; i++) send_item(random_item(), gap_pct);
  endtask

  task automatic set_random_regs(int unsigned be);
    set_regs($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
             $urandom_range(100000), $urandom_range(1, 16), be);
  endtask

  initial begin
    rst       <= 1'b1;
    start     <= 1'b0;
    item      <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      q_shadow[i] = 0;
      visit_dest[i] = 0;
      visit_reward[i] = 0;
      visit_seen[i] = 0;
      visit_stamp[i] = 0;
    end
    real_steps = 0;
    alpha_q = 6554;
    gamma_q = 58982;
    kappa_q = 6554;
    eps_thr = 10000;
    cells_per_row = 9;
    bonus_on = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    // sender inserts an idle gap before 15 percent of items
    set_regs(6554, 58982, 6554, 10000, 4, 0);
    test_random(110, 15);
    set_regs(65535, 0, 65535, 0, 1, 1);
    test_random(110, 15);
    // sender inserts an idle gap before 48 percent of items
    set_regs(0, 65535, 0, 100000, 16, 0);
    test_random(110, 48);
    set_random_regs(1);
    test_random(110, 48);
    // no idling
    set_random_regs(0);
    test_random(100, 0);
    set_regs(40000, 60000, 30000, 30000, 4, 1);
    test_random(100, 0);

    drain();
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("dyna_q_table_update test passed");
    end else begin
      $display("dyna_q_table_update test failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("dyna_q_table_update test failed");
    $finish;
  end

endmodule
